### rtl/miu_pkg.sv
package miu_pkg;

  typedef enum logic [4:0] {
    OP_ADD   = 5'd0,
    OP_ADDI  = 5'd1,
    OP_SUB   = 5'd2,
    OP_AND   = 5'd3,
    OP_OR    = 5'd4,
    OP_XOR   = 5'd5,
    OP_NOR   = 5'd6,
    OP_SLT   = 5'd7,
    OP_SLTI  = 5'd8,
    OP_ANDI  = 5'd9,
    OP_ORI   = 5'd10,
    OP_XORI  = 5'd11,
    OP_LUI   = 5'd12,
    OP_SLL   = 5'd13,
    OP_SRL   = 5'd14,
    OP_SRA   = 5'd15,
    OP_JAL   = 5'd16,
    OP_J     = 5'd17,
    OP_JR    = 5'd18,
    OP_BEQ   = 5'd19,
    OP_BNE   = 5'd20,
    OP_BLTU  = 5'd21,
    OP_MFHI  = 5'd22,
    OP_MFLO  = 5'd23,
    OP_MULTU = 5'd24
  } op_e;

  localparam logic [31:0] RegionMask = 32'hF000_0000;
  localparam logic [31:0] ResetPc    = 32'h0040_0000;
  localparam logic [4:0]  LinkReg    = 5'd31;

  typedef struct packed {
    logic [4:0]  mode;
    logic [4:0]  dest_reg;
    logic [4:0]  src_a;
    logic [4:0]  src_b;
    logic [15:0] immediate;
    logic [4:0]  shift_amount;
    logic [25:0] jump_target;
  } instr_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        reg_written;
    logic [4:0]  written_index;
    logic [31:0] written_value;
  } result_t;

endpackage

### rtl/miu_instr_if.sv
interface miu_instr_if;
  import miu_pkg::*;
  logic   valid;
  logic   ready;
  instr_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/miu_result_if.sv
interface miu_result_if;
  import miu_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/miu_ram.sv
module miu_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### rtl/miu_regfile.sv
// Register file: two read-port copies of one RAM, valid bits for reset-zero,
// write-to-read bypass for the cycle after a write. While no new read is
// issued the RAMs keep re-reading the held addresses.
module miu_regfile import miu_pkg::*; #(
  parameter int RegCount = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [4:0]  raddr_a_i,
  input  logic [4:0]  raddr_b_i,
  input  logic        re_i,
  input  logic        we_i,
  input  logic [4:0]  waddr_i,
  input  logic [31:0] wdata_i,
  output logic [31:0] rdata_a_o,
  output logic [31:0] rdata_b_o
);
  localparam int Aw = (RegCount > 1) ? $clog2(RegCount) : 1;

  logic [31:0]       ram_a, ram_b;
  logic [RegCount-1:0] valid_q;
  logic [4:0]        ra_q, rb_q;
  logic              byp_a_q, byp_b_q;
  logic [31:0]       byp_val_q;
  logic [4:0]        rd_addr_a, rd_addr_b;

  function automatic logic in_range(logic [4:0] idx);
    return (idx != 5'd0) && ({27'd0, idx} < RegCount);
  endfunction

  // hold the read address of a waiting word
  assign rd_addr_a = re_i ? raddr_a_i : ra_q;
  assign rd_addr_b = re_i ? raddr_b_i : rb_q;

  miu_ram #(.Width(32), .Depth(RegCount)) u_ram_a (
    .clk_i, .we_i(we_i), .waddr_i(waddr_i[Aw-1:0]), .wdata_i(wdata_i),
    .raddr_i(rd_addr_a[Aw-1:0]), .rdata_o(ram_a)
  );
  miu_ram #(.Width(32), .Depth(RegCount)) u_ram_b (
    .clk_i, .we_i(we_i), .waddr_i(waddr_i[Aw-1:0]), .wdata_i(wdata_i),
    .raddr_i(rd_addr_b[Aw-1:0]), .rdata_o(ram_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[waddr_i[Aw-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      ra_q    <= raddr_a_i;
      rb_q    <= raddr_b_i;
      byp_a_q <= we_i && (waddr_i == raddr_a_i);
      byp_b_q <= we_i && (waddr_i == raddr_b_i);
    end else begin
      byp_a_q <= byp_a_q || (we_i && (waddr_i == ra_q));
      byp_b_q <= byp_b_q || (we_i && (waddr_i == rb_q));
    end
    if (we_i) begin
      byp_val_q <= wdata_i;
    end
  end

  always_comb begin
    rdata_a_o = '0;
    rdata_b_o = '0;
    if (in_range(ra_q)) begin
      if (byp_a_q)                   rdata_a_o = byp_val_q;
      else if (valid_q[ra_q[Aw-1:0]]) rdata_a_o = ram_a;
    end
    if (in_range(rb_q)) begin
      if (byp_b_q)                   rdata_b_o = byp_val_q;
      else if (valid_q[rb_q[Aw-1:0]]) rdata_b_o = ram_b;
    end
  end
endmodule

### rtl/mips_integer_execute_unit.sv
// Channel | Dir | Payload
// in      | in  | mode, dest_reg, src_a, src_b, immediate, shift_amount, jump_target
// out     | out | next_pc, reg_written, written_index, written_value
// cfg     | in  | start_address (cfg_we_i / cfg_wdata_i)
//
// Two-stage: stage 0 accepts a word and issues register reads; stage 1 gets
// the RAM data in the next cycle, executes, and writes back. One word per
// cycle unless the output or a multu stalls. Back-to-back dependencies are
// covered by the register file write bypass. While a word waits in stage 1
// the register file re-reads its addresses, so its operands stay valid across
// output stalls. Reset clears PC to 0x00400000, HI/LO and the register file
// valid bits, not the RAM; multu stalls to register 16-bit partial products.
module mips_integer_execute_unit import miu_pkg::*; #(
  parameter int RegCount = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [31:0]  cfg_wdata_i,
  miu_instr_if.sink    in_i,
  miu_result_if.source out_o
);
  logic        s1_valid_q;
  instr_t      s1_q;
  logic [31:0] pc_q, hi_q, lo_q;
  logic        out_valid_q;
  result_t     out_q;
  logic        mul_busy_q;
  logic [31:0] pp_ll_q, pp_lh_q, pp_hl_q, pp_hh_q;

  logic [31:0] a, b;
  logic        s1_fire, s1_stall, is_mul;
  logic        wr;
  logic [4:0]  widx;
  logic [31:0] wval, pc_inc, pc_nx, imm_s, imm_z;

  assign is_mul   = s1_valid_q && (s1_q.mode == OP_MULTU);
  // multu: stall while the partial products are formed and registered, then commit
  assign s1_stall = (out_valid_q && !out_o.ready) || (is_mul && !mul_busy_q);
  assign s1_fire  = s1_valid_q && !s1_stall;
  assign in_i.ready = !s1_valid_q || s1_fire;

  logic we_rf;
  assign we_rf = s1_fire && wr;

  miu_regfile #(.RegCount(RegCount)) u_rf (
    .clk_i, .rst_ni,
    .raddr_a_i(in_i.data.src_a), .raddr_b_i(in_i.data.src_b),
    .re_i(in_i.valid && in_i.ready),
    .we_i(we_rf), .waddr_i(widx), .wdata_i(wval),
    .rdata_a_o(a), .rdata_b_o(b)
  );

  always_comb begin
    imm_s  = {{16{s1_q.immediate[15]}}, s1_q.immediate};
    imm_z  = {16'd0, s1_q.immediate};
    pc_inc = pc_q + 32'd4;
    pc_nx  = pc_inc;
    wr     = 1'b0;
    widx   = s1_q.dest_reg;
    wval   = '0;
    case (s1_q.mode)
      OP_ADD:  begin wr = 1'b1; wval = a + b; end
      OP_ADDI: begin wr = 1'b1; widx = s1_q.src_b; wval = a + imm_s; end
      OP_SUB:  begin wr = 1'b1; wval = a - b; end
      OP_AND:  begin wr = 1'b1; wval = a & b; end
      OP_OR:   begin wr = 1'b1; wval = a | b; end
      OP_XOR:  begin wr = 1'b1; wval = a ^ b; end
      OP_NOR:  begin wr = 1'b1; wval = ~(a | b); end
      OP_SLT:  begin wr = 1'b1; wval = {31'd0, $signed(a) < $signed(b)}; end
      OP_SLTI: begin
        wr = 1'b1; widx = s1_q.src_b; wval = {31'd0, $signed(a) < $signed(imm_s)};
      end
      OP_ANDI: begin wr = 1'b1; widx = s1_q.src_b; wval = a & imm_z; end
      OP_ORI:  begin wr = 1'b1; widx = s1_q.src_b; wval = a | imm_z; end
      OP_XORI: begin wr = 1'b1; widx = s1_q.src_b; wval = a ^ imm_z; end
      OP_LUI:  begin wr = 1'b1; widx = s1_q.src_b; wval = {s1_q.immediate, 16'd0}; end
      OP_SLL:  begin wr = 1'b1; wval = b << s1_q.shift_amount; end
      OP_SRL:  begin wr = 1'b1; wval = b >> s1_q.shift_amount; end
      OP_SRA:  begin wr = 1'b1; wval = $unsigned($signed(b) >>> s1_q.shift_amount); end
      OP_JAL:  begin
        wr = 1'b1; widx = LinkReg; wval = pc_inc;
        pc_nx = (pc_inc & RegionMask) | {4'd0, s1_q.jump_target, 2'b00};
      end
      OP_J:    pc_nx = (pc_inc & RegionMask) | {4'd0, s1_q.jump_target, 2'b00};
      OP_JR:   pc_nx = a;
      OP_BEQ:  if (a == b) pc_nx = pc_inc + {imm_s[29:0], 2'b00};
      OP_BNE:  if (a != b) pc_nx = pc_inc + {imm_s[29:0], 2'b00};
      OP_BLTU: if (a < b)  pc_nx = pc_inc + {imm_s[29:0], 2'b00};
      OP_MFHI: begin wr = 1'b1; wval = hi_q; end
      OP_MFLO: begin wr = 1'b1; wval = lo_q; end
      default: ;
    endcase
    // register zero and indexes past the file are never written
    if (widx == 5'd0 || {27'd0, widx} >= RegCount) wr = 1'b0;
    if (!wr) begin
      widx = '0;
      wval = '0;
    end
  end

  logic [63:0] prod;
  assign prod = {pp_hh_q, pp_ll_q} + {16'd0, pp_lh_q, 16'd0} + {16'd0, pp_hl_q, 16'd0};

  always_ff @(posedge clk_i) begin
    if (is_mul && !mul_busy_q) begin
      pp_ll_q <= a[15:0]  * b[15:0];
      pp_lh_q <= a[15:0]  * b[31:16];
      pp_hl_q <= a[31:16] * b[15:0];
      pp_hh_q <= a[31:16] * b[31:16];
    end
    if (in_i.valid && in_i.ready) s1_q <= in_i.data;
    if (s1_fire) out_q <= '{next_pc: pc_nx, reg_written: wr,
                           written_index: widx, written_value: wval};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      mul_busy_q  <= 1'b0;
      pc_q        <= ResetPc;
      hi_q        <= '0;
      lo_q        <= '0;
    end else begin
      if (in_i.ready) s1_valid_q <= in_i.valid;
      mul_busy_q <= is_mul && !mul_busy_q;
      if (s1_fire) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
      if (cfg_we_i) pc_q <= cfg_wdata_i;
      else if (s1_fire) pc_q <= pc_nx;
      if (s1_fire && is_mul) begin
        hi_q <= prod[63:32];
        lo_q <= prod[31:0];
      end
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;
endmodule
